@@ hw/rtl/arm_pkg.sv @@
`default_nettype none
package arm_pkg;
    localparam int ADDR_W = 64;
    localparam int PROT_W = 3;
    localparam int TAG_W = 16;
    localparam int STATUS_W = 3;
    localparam int MAX_REGIONS_DEF = 32;
    localparam int TAG_BITS_DEF = 16;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [PROT_W-1:0] prot;
        logic [TAG_W-1:0]  tag;
    } entry_t;
endpackage
`default_nettype wire

@@ hw/rtl/address_region_map_core.sv @@
`default_nettype none
// Region map: up to MAX_REGIONS non-overlapping [start, end) regions held in
// one single-port-read memory with valid bits in flops. A lookup scans all
// slots, one read per cycle. An insert makes a counting scan; if the new region
// would not fit, it ends there with the full status, else an update scan (read,
// trim/clear, write back) follows; then, when a region was split, its upper
// piece is written to a free slot, and last the new region is written.
// Empty ranges answer in the cycle right after the transfer. busy is high from
// acceptance until the result strobe; the result is shown for one cycle in
// done, and the receiver cannot stall it, so sample it in that cycle.
module address_region_map_core
#(
    parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF,
    parameter int TAG_BITS = arm_pkg::TAG_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          opcode,
    input  wire logic [arm_pkg::ADDR_W-1:0]    address,
    input  wire logic [arm_pkg::ADDR_W-1:0]    range_end,
    input  wire logic [arm_pkg::PROT_W-1:0]    prot,
    input  wire logic [arm_pkg::TAG_W-1:0]     region_tag,
    output logic                               done,
    output logic [arm_pkg::STATUS_W-1:0]       status,
    output logic [arm_pkg::ADDR_W-1:0]         hit_start,
    output logic [arm_pkg::ADDR_W-1:0]         hit_end,
    output logic [arm_pkg::PROT_W-1:0]         hit_prot,
    output logic [arm_pkg::TAG_W-1:0]          hit_tag
);
    import arm_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 2) + 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(MAX_REGIONS - 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_REGIONS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_COUNT = 3'd2;
    localparam logic [2:0] S_UPD = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_NEW = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] rd_ptr_next;
    logic rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_q_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [MAX_REGIONS-1:0] valid_reg;
    logic [MAX_REGIONS-1:0] valid_next;
    logic op_reg;
    logic [ADDR_W-1:0] s_reg;
    logic [ADDR_W-1:0] e_reg;
    logic [PROT_W-1:0] p_reg;
    logic [TAG_W-1:0] t_reg;
    logic split_reg;
    logic split_next;
    entry_t sp_reg;
    entry_t sp_next;
    logic found_reg;
    logic found_next;
    entry_t hit_reg;
    entry_t hit_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic done_reg;

    logic [IDX_W-1:0] rd_idx;
    entry_t rd_data;
    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t wr_data;
    logic [IDX_W-1:0] free_idx;
    logic ent_v;
    logic overlap;
    logic left_part;
    logic right_part;
    logic [TAG_W-1:0] tag_mask;

    assign tag_mask = TAG_W'((33'd1 << TAG_BITS) - 33'd1);

    arm_store #(.MAX_REGIONS(MAX_REGIONS), .IDX_W(IDX_W)) u_store
    (
        .clk(clk), .rd_idx(rd_idx), .rd_data(rd_data),
        .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
    );

    assign rd_idx = rd_ptr_reg[IDX_W-1:0];
    assign ent_v = rd_vld_reg && valid_reg[rd_idx_q_reg];
    assign overlap = !(rd_data.end_addr <= s_reg || rd_data.start_addr >= e_reg);
    assign left_part = rd_data.start_addr < s_reg;
    assign right_part = rd_data.end_addr > e_reg;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_REGIONS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        split_next = split_reg;
        sp_next = sp_reg;
        found_next = found_reg;
        hit_next = hit_reg;
        status_next = status_reg;
        wr_en = 1'b0;
        wr_idx = rd_idx_q_reg;
        wr_data = rd_data;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rd_ptr_next = '0;
                    count_next = CNT_W'(1);
                    split_next = 1'b0;
                    found_next = 1'b0;
                    if (opcode == OP_LOOKUP)
                    begin
                        state_next = S_LOOK;
                    end
                    else if (address >= range_end)
                    begin
                        status_next = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_COUNT;
                    end
                end
            end
            S_LOOK:
            begin
                if (rd_ptr_reg <= LAST)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (ent_v && !found_reg && s_reg >= rd_data.start_addr
                    && s_reg < rd_data.end_addr)
                begin
                    found_next = 1'b1;
                    hit_next = rd_data;
                end
                if (rd_vld_reg && rd_idx_q_reg == LAST[IDX_W-1:0])
                begin
                    status_next = ST_MISS;
                    if (found_next)
                    begin
                        status_next = ST_HIT;
                    end
                    state_next = S_DONE;
                end
            end
            S_COUNT:
            begin
                if (rd_ptr_reg <= LAST)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (ent_v)
                begin
                    if (!overlap)
                    begin
                        count_next = count_next + 1'b1;
                    end
                    else
                    begin
                        count_next = count_next + CNT_W'(left_part) + CNT_W'(right_part);
                    end
                end
                if (rd_vld_reg && rd_idx_q_reg == LAST[IDX_W-1:0])
                begin
                    if (count_next > CAP)
                    begin
                        status_next = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_ptr_next = '0;
                        state_next = S_UPD;
                    end
                end
            end
            S_UPD:
            begin
                if (rd_ptr_reg <= LAST)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (ent_v && overlap)
                begin
                    if (left_part && right_part)
                    begin
                        split_next = 1'b1;
                        sp_next = rd_data;
                        sp_next.start_addr = e_reg;
                        wr_en = 1'b1;
                        wr_data.end_addr = s_reg;
                    end
                    else if (left_part)
                    begin
                        wr_en = 1'b1;
                        wr_data.end_addr = s_reg;
                    end
                    else if (right_part)
                    begin
                        wr_en = 1'b1;
                        wr_data.start_addr = e_reg;
                    end
                    else
                    begin
                        valid_next[rd_idx_q_reg] = 1'b0;
                    end
                end
                if (rd_vld_reg && rd_idx_q_reg == LAST[IDX_W-1:0])
                begin
                    state_next = split_next ? S_SPLIT : S_NEW;
                end
            end
            S_SPLIT:
            begin
                wr_en = 1'b1;
                wr_idx = free_idx;
                wr_data = sp_reg;
                valid_next[free_idx] = 1'b1;
                state_next = S_NEW;
            end
            S_NEW:
            begin
                wr_en = 1'b1;
                wr_idx = free_idx;
                wr_data.start_addr = s_reg;
                wr_data.end_addr = e_reg;
                wr_data.prot = p_reg;
                wr_data.tag = t_reg;
                valid_next[free_idx] = 1'b1;
                status_next = ST_INSERTED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rd_ptr_reg <= '0;
            rd_vld_reg <= 1'b0;
            count_reg <= '0;
            valid_reg <= '0;
            split_reg <= 1'b0;
            found_reg <= 1'b0;
            done_reg <= 1'b0;
            status_reg <= ST_MISS;
        end
        else
        begin
            state_reg <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            // read data valid in the cycle after address issue
            rd_vld_reg <= (state_reg == S_LOOK || state_reg == S_COUNT
                           || state_reg == S_UPD) && state_next == state_reg
                          && rd_ptr_reg <= LAST;
            count_reg <= count_next;
            valid_reg <= valid_next;
            split_reg <= split_next;
            found_reg <= found_next;
            done_reg <= (state_next == S_DONE);
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_q_reg <= rd_idx;
        sp_reg <= sp_next;
        hit_reg <= hit_next;
        if (state_reg == S_IDLE && start)
        begin
            op_reg <= opcode;
            s_reg <= address;
            e_reg <= range_end;
            p_reg <= prot;
            t_reg <= region_tag & tag_mask;
        end
    end

    // done_reg rises on entry to S_DONE; strobe is that cycle
    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign status = status_reg;
    assign hit_start = (status_reg == ST_HIT) ? hit_reg.start_addr : '0;
    assign hit_end = (status_reg == ST_HIT) ? hit_reg.end_addr : '0;
    assign hit_prot = (status_reg == ST_HIT) ? hit_reg.prot : '0;
    assign hit_tag = (status_reg == ST_HIT) ? hit_reg.tag : '0;

    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_DONE)
        else $error("strobe outside done state");
    a_hit_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_HIT |-> op_reg == OP_LOOKUP)
        else $error("hit on insert");
    a_insert_op: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_INSERTED |-> op_reg == OP_INSERT)
        else $error("insert status on lookup");
    a_full_nochange: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> $stable(valid_reg))
        else $error("table changed on full");
endmodule
`default_nettype wire

@@ hw/rtl/arm_store.sv @@
`default_nettype none
module arm_store
#(
    parameter int MAX_REGIONS = arm_pkg::MAX_REGIONS_DEF,
    parameter int IDX_W = $clog2(MAX_REGIONS)
)
(
    input  wire logic                 clk,
    input  wire logic [IDX_W-1:0]     rd_idx,
    output arm_pkg::entry_t           rd_data,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_idx,
    input  arm_pkg::entry_t           wr_data
);
    import arm_pkg::*;

    entry_t mem [MAX_REGIONS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire
